// ===== src/deqs_pkg.sv =====
package deqs_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_PEEK       = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EDIT,
        ST_DONE
    } fsm_state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_WRITE_TAIL,
        CELL_MARK,
        CELL_SCAN,
        CELL_REMOVE_AT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic signed [31:0] data;
    } cell_ctl_t;

endpackage

// ===== src/deqs_cell.sv =====
module deqs_cell #(
    parameter int unsigned CW  = 5,
    parameter int unsigned IDX = 0
) (
    input  logic                aclk,
    input  deqs_pkg::cell_ctl_t ctl,
    input  logic [CW-1:0]       count,
    input  logic signed [31:0]  left_val,
    input  logic                left_seen,
    input  logic signed [31:0]  right_val,
    output logic signed [31:0]  val,
    output logic                seen
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               seen_reg;
    logic               seen_next;
    logic               occupied;

    assign occupied = CW'(IDX) < count;

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        seen_reg  <= seen_next;
    end

    always_comb begin
        value_next = value_reg;
        seen_next  = seen_reg;
        unique case (ctl.cmd)
            deqs_pkg::CELL_HOLD: begin
            end
            deqs_pkg::CELL_SHIFT_RIGHT: begin
                value_next = left_val;
            end
            deqs_pkg::CELL_SHIFT_LEFT: begin
                value_next = right_val;
            end
            deqs_pkg::CELL_WRITE_TAIL: begin
                if (CW'(IDX) == count) begin
                    value_next = ctl.data;
                end
            end
            deqs_pkg::CELL_MARK: begin
                seen_next = occupied && (value_reg == ctl.data);
            end
            deqs_pkg::CELL_SCAN: begin
                seen_next = seen_reg | left_seen;
            end
            deqs_pkg::CELL_REMOVE_AT: begin
                if (seen_reg) begin
                    value_next = right_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign val  = value_reg;
    assign seen = seen_reg;

endmodule

// ===== src/double_ended_queue_with_search_unit.sv =====
// Pushes, pops and peek pass through the exec and done states before their result is registered.
// Contains and remove on a nonempty queue also pass through the scan and edit states between them:
// the match flags travel one cell per cycle along the chain while in the scan state.
// One item is in work at a time, so a new transfer is taken only after the done state has
// handed the last result to the output registers; a new item is taken while a result waits.
// Synchronous active-low reset empties the queue and clears the handshakes.
module double_ended_queue_with_search_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic signed [31:0] s_data_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic               m_found,
    output logic signed [31:0] m_front_value,
    output logic signed [31:0] m_back_value,
    output logic [4:0]         m_entry_count,
    output logic               m_is_empty
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);

    deqs_pkg::fsm_state_t state_reg, state_next;
    deqs_pkg::opcode_t    op_reg, op_next;
    deqs_pkg::status_t    status_reg, status_next;
    logic signed [31:0]   data_reg, data_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        scan_reg, scan_next;
    logic                 found_reg, found_next;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic                 m_found_reg, m_found_next;
    logic signed [31:0]   m_front_reg, m_front_next;
    logic signed [31:0]   m_back_reg, m_back_next;
    logic [4:0]           m_count_reg, m_count_next;
    logic                 m_empty_reg, m_empty_next;

    deqs_pkg::cell_ctl_t  ctl;
    logic signed [31:0]   cell_val [DEPTH];
    logic                 cell_seen [DEPTH];
    logic [CW-1:0]        tail_pos;

    assign tail_pos = count_reg - CW'(1);

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [31:0] left_val;
        logic               left_seen;
        logic signed [31:0] right_val;

        if (k == 0) begin : g_head
            assign left_val  = data_reg;
            assign left_seen = 1'b0;
        end else begin : g_body
            assign left_val  = cell_val[k-1];
            assign left_seen = cell_seen[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = cell_val[k+1];
        end

        deqs_cell #(
            .CW  (CW),
            .IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .count     (count_reg),
            .left_val  (left_val),
            .left_seen (left_seen),
            .right_val (right_val),
            .val       (cell_val[k]),
            .seen      (cell_seen[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= deqs_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        data_reg     <= data_next;
        status_reg   <= status_next;
        scan_reg     <= scan_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_front_reg  <= m_front_next;
        m_back_reg   <= m_back_next;
        m_count_reg  <= m_count_next;
        m_empty_reg  <= m_empty_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_front_next  = m_front_reg;
        m_back_next   = m_back_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;
        ctl.cmd       = deqs_pkg::CELL_HOLD;
        ctl.data      = data_reg;
        s_ready       = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            deqs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = deqs_pkg::opcode_t'(s_opcode);
                    data_next  = s_data_value;
                    state_next = deqs_pkg::ST_EXEC;
                end
            end
            deqs_pkg::ST_EXEC: begin
                status_next = deqs_pkg::STATUS_OK;
                found_next  = 1'b0;
                state_next  = deqs_pkg::ST_DONE;
                unique case (op_reg)
                    deqs_pkg::OP_PUSH_FRONT, deqs_pkg::OP_PUSH_BACK: begin
                        if (count_reg == CW'(DEPTH)) begin
                            status_next = deqs_pkg::STATUS_FULL;
                        end else begin
                            ctl.cmd    = (op_reg == deqs_pkg::OP_PUSH_FRONT) ?
                                         deqs_pkg::CELL_SHIFT_RIGHT :
                                         deqs_pkg::CELL_WRITE_TAIL;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    deqs_pkg::OP_POP_FRONT, deqs_pkg::OP_POP_BACK: begin
                        if (count_reg == '0) begin
                            status_next = deqs_pkg::STATUS_EMPTY;
                        end else begin
                            if (op_reg == deqs_pkg::OP_POP_FRONT) begin
                                ctl.cmd = deqs_pkg::CELL_SHIFT_LEFT;
                            end
                            count_next = tail_pos;
                        end
                    end
                    deqs_pkg::OP_CONTAINS, deqs_pkg::OP_REMOVE: begin
                        if (count_reg == '0) begin
                            status_next = deqs_pkg::STATUS_EMPTY;
                        end else begin
                            ctl.cmd    = deqs_pkg::CELL_MARK;
                            scan_next  = '0;
                            state_next = deqs_pkg::ST_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            deqs_pkg::ST_SCAN: begin
                ctl.cmd   = deqs_pkg::CELL_SCAN;
                scan_next = scan_reg + IW'(1);
                if (scan_reg == IW'(DEPTH - 2)) begin
                    state_next = deqs_pkg::ST_EDIT;
                end
            end
            deqs_pkg::ST_EDIT: begin
                found_next = cell_seen[DEPTH-1];
                if (op_reg == deqs_pkg::OP_REMOVE && cell_seen[DEPTH-1]) begin
                    ctl.cmd    = deqs_pkg::CELL_REMOVE_AT;
                    count_next = tail_pos;
                end
                state_next = deqs_pkg::ST_DONE;
            end
            deqs_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = found_reg;
                    m_front_next  = (count_reg != '0) ? cell_val[0] : '0;
                    m_back_next   = (count_reg != '0) ? cell_val[tail_pos[IW-1:0]] : '0;
                    m_count_next  = deqs_pkg::COUNT_W'(count_reg);
                    m_empty_next  = (count_reg == '0);
                    state_next    = deqs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = deqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found       = m_found_reg;
    assign m_front_value = m_front_reg;
    assign m_back_value  = m_back_reg;
    assign m_entry_count = m_count_reg;
    assign m_is_empty    = m_empty_reg;

endmodule

// ===== src/deqs_checker.sv =====
module deqs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic               m_found,
    input logic signed [31:0] m_front_value,
    input logic signed [31:0] m_back_value,
    input logic [4:0]         m_entry_count,
    input logic               m_is_empty
);

    // Only one item is in work, so an input transfer closes the input side.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a transfer");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_status == deqs_pkg::STATUS_OK)
        else $error("match reported on a rejected item");

    a_empty_view: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |->
            m_entry_count == 5'd0 && m_front_value == 32'sd0 && m_back_value == 32'sd0)
        else $error("empty result shows stored values");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == deqs_pkg::STATUS_FULL |-> !m_is_empty)
        else $error("full rejection on an empty queue");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_front_value))
        else $error("stalled result changed");

endmodule

bind double_ended_queue_with_search_unit deqs_checker u_deqs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found       (m_found),
    .m_front_value (m_front_value),
    .m_back_value  (m_back_value),
    .m_entry_count (m_entry_count),
    .m_is_empty    (m_is_empty)
);
